// ----- rtl/lccp_pkg.sv -----
// Shared constants and types for the coefficient compress-and-pack block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package lccp_pkg;

  localparam int MODULUS  = 3329;
  localparam int HALF_MOD = MODULUS / 2;

  localparam int COEF_W    = 16;
  localparam int VAL_W     = 12;
  localparam int WID_W     = 4;
  localparam int RAW_WIDTH = 12;
  localparam logic [WID_W-1:0] RESET_WIDTH = 4'd4;

  // (u << 11) + MODULUS/2 stays below 2^27.
  localparam int NUM_W       = 27;
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 21;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int QUO_W       = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / MODULUS);

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = 3;
  localparam int QCNT_W      = 4;

  localparam int PEND_W = 7;
  localparam int PCNT_W = 3;
  localparam int ACC_W  = PEND_W + VAL_W;
  localparam int ACNT_W = 5;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [WID_W-1:0] width;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/lccp_front.sv -----
// Front end: accepts coefficients, normalizes them and computes the compressed value.
// Three-stage pipeline with reciprocal division; depends on lccp_pkg.
`default_nettype none

module lccp_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lccp_pkg::WID_W-1:0]   coeff_bits,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lccp_pkg::COEF_W-1:0]  coefficient,
  input  logic [lccp_pkg::QCNT_W-1:0]  queue_count,
  output logic                         push,
  output lccp_pkg::entry_t             push_entry
);
  import lccp_pkg::*;

  logic                v0, v1, v2;
  logic [COEF_W-1:0]   u0;
  logic [WID_W-1:0]    d0, d1, d2;
  logic [NUM_W-1:0]    num1, num2;
  logic [VAL_W-1:0]    raw1, raw2;
  logic [PROD_W-1:0]   prod2;

  logic [QCNT_W-1:0]   committed;
  logic                accept;
  logic [COEF_W-1:0]   norm;
  logic [WID_W-1:0]    width_eff;
  logic [QUO_W-1:0]    quo_est;
  logic [NUM_W-1:0]    rem;
  logic [QUO_W-1:0]    quo;
  logic [VAL_W-1:0]    mask;

  // The pipeline never stalls: an item is only taken when the queue is sure
  // to have room for it and for everything already in flight.
  assign committed = queue_count + QCNT_W'(v0) + QCNT_W'(v1) + QCNT_W'(v2);
  assign in_stall  = committed >= QCNT_W'(QUEUE_DEPTH);
  assign accept    = in_valid && !in_stall;

  assign norm      = coefficient[COEF_W-1] ? coefficient + COEF_W'(MODULUS) : coefficient;
  assign width_eff = (coeff_bits > WID_W'(RAW_WIDTH)) ? WID_W'(RAW_WIDTH) : coeff_bits;

  // The reciprocal estimate is at most one low; a single compare fixes it.
  assign quo_est = prod2[RECIP_SHIFT +: QUO_W];
  assign rem     = num2 - NUM_W'(quo_est * MODULUS);
  assign quo     = quo_est + QUO_W'(rem >= NUM_W'(MODULUS));
  assign mask    = ~({VAL_W{1'b1}} << d2);

  assign push             = v2;
  assign push_entry.width = d2;
  assign push_entry.value = (d2 >= WID_W'(RAW_WIDTH)) ? raw2 : (quo[VAL_W-1:0] & mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    u0    <= norm;
    d0    <= width_eff;
    num1  <= (NUM_W'(u0) << d0) + NUM_W'(HALF_MOD);
    raw1  <= u0[VAL_W-1:0];
    d1    <= d0;
    prod2 <= {{RECIP_W{1'b0}}, num1} * {{NUM_W{1'b0}}, RECIP};
    num2  <= num1;
    raw2  <= raw1;
    d2    <= d1;
  end

endmodule

`default_nettype wire

// ----- rtl/lccp_queue.sv -----
// Short first-in first-out queue of compressed values between front and back.
// Register storage read at the head only; depends on lccp_pkg.
`default_nettype none

module lccp_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  lccp_pkg::entry_t             push_entry,
  input  logic                         pop,
  output logic                         head_valid,
  output lccp_pkg::entry_t             head_entry,
  output logic [lccp_pkg::QCNT_W-1:0]  count
);
  import lccp_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;

  assign head_valid = count != '0;
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lccp_back.sv -----
// Back end: appends compressed values to the pending bits and emits whole bytes.
// Holds the pending bit state and a two-byte output stage; depends on lccp_pkg.
`default_nettype none

module lccp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  lccp_pkg::entry_t  head_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        packed_byte,
  output logic              run_last
);
  import lccp_pkg::*;

  logic [PEND_W-1:0]  pending_bits;
  logic [PCNT_W-1:0]  pending_count;
  logic               second_valid;
  logic [7:0]         second_byte;

  logic [ACC_W-1:0]   acc;
  logic [ACNT_W-1:0]  cnt;
  logic               one_byte;
  logic               two_bytes;
  logic [ACC_W-1:0]   left;
  logic [PCNT_W-1:0]  pending_count_next;
  logic [PEND_W-1:0]  pending_bits_next;
  logic               out_free;

  assign acc       = ACC_W'(pending_bits) | (ACC_W'(head_entry.value) << pending_count);
  assign cnt       = ACNT_W'(pending_count) + ACNT_W'(head_entry.width);
  assign two_bytes = cnt >= ACNT_W'(16);
  assign one_byte  = cnt >= ACNT_W'(8);
  assign left      = two_bytes ? (acc >> 16) : (one_byte ? (acc >> 8) : acc);

  // At most 19 bits are held, so the leftover count is simply the low three bits.
  assign pending_count_next = cnt[PCNT_W-1:0];
  assign pending_bits_next  = left[PEND_W-1:0] & ~({PEND_W{1'b1}} << pending_count_next);

  assign out_free = !out_valid || !out_stall;
  assign pop      = out_free && !second_valid && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      second_valid  <= 1'b0;
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (out_free) begin
      if (second_valid) begin
        out_valid    <= 1'b1;
        second_valid <= 1'b0;
      end else if (head_valid) begin
        out_valid     <= one_byte;
        second_valid  <= two_bytes;
        pending_bits  <= pending_bits_next;
        pending_count <= pending_count_next;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (second_valid) begin
        packed_byte <= second_byte;
        run_last    <= 1'b1;
      end else begin
        packed_byte <= acc[7:0];
        run_last    <= !two_bytes;
        second_byte <= acc[15:8];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lattice_coeff_compress_pack.sv -----
// Coefficients pass the three front stages, the queue and the output register.
// Throughput: one coefficient per cycle in while in_stall is low, one byte per cycle
// out while out_stall is low, so a coefficient that completes two bytes holds the back
// end until both are out. An 8-entry queue absorbs the difference.
// Reset (synchronous, active high) empties the pipeline and queue, drops the pending
// bits and sets the width register to 4. Top level; depends on lccp_pkg and submodules.
`default_nettype none

module lattice_coeff_compress_pack (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [lccp_pkg::WID_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lccp_pkg::COEF_W-1:0]  coefficient,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   packed_byte,
  output logic                         run_last
);
  import lccp_pkg::*;

  logic [WID_W-1:0]   coeff_bits;
  logic               push;
  entry_t             push_entry;
  logic               pop;
  logic               head_valid;
  entry_t             head_entry;
  logic [QCNT_W-1:0]  queue_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_bits <= RESET_WIDTH;
    end else if (cfg_wr_en) begin
      coeff_bits <= cfg_wr_data;
    end
  end

  lccp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .coeff_bits  (coeff_bits),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .coefficient (coefficient),
    .queue_count (queue_count),
    .push        (push),
    .push_entry  (push_entry)
  );

  lccp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .count      (queue_count)
  );

  lccp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_entry  (head_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .packed_byte (packed_byte),
    .run_last    (run_last)
  );

endmodule

`default_nettype wire
